[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands shared by the unpacker RTL. With SYNTH
// defined they expand to nothing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Expression holds at every clock edge out of reset.
`define ASSERT_HOLDS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(label, clk, rst, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[src/btpu_pkg.sv]
// ----------------------------------------------------------------------------
// Bitstream unpacker package
// Widths, register indexes, channel order codes, transfer types and helpers
// shared by the unpacker and its scaling unit.
// ----------------------------------------------------------------------------
`default_nettype none

package btpu_pkg;

   // Limits
   localparam int MAX_CHANNEL_BITS = 16;
   localparam int MAX_ROW_WIDTH    = 4096;

   // Field and register widths
   localparam int DATA_W     = 8;
   localparam int PIX_W      = 8;
   localparam int COL_W      = 12;
   localparam int ROW_W      = 13;
   localparam int SKIP_W     = 24;
   localparam int NBITS_W    = 5;
   localparam int ORDER_W    = 3;
   localparam int STORE_W    = 56;
   localparam int HELD_W     = 6;
   localparam int VAL_W      = MAX_CHANNEL_BITS;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_RED_BITS      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GREEN_BITS    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BLUE_BITS     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GRAY_BITS     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_ORDER = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_WIDTH     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SKIP_BYTES    = 3'd6;

   // Channel order codes
   localparam logic [ORDER_W-1:0] ORDER_RGB  = 3'd0;
   localparam logic [ORDER_W-1:0] ORDER_RBG  = 3'd1;
   localparam logic [ORDER_W-1:0] ORDER_GBR  = 3'd2;
   localparam logic [ORDER_W-1:0] ORDER_GRB  = 3'd3;
   localparam logic [ORDER_W-1:0] ORDER_BRG  = 3'd4;
   localparam logic [ORDER_W-1:0] ORDER_BGR  = 3'd5;
   localparam logic [ORDER_W-1:0] ORDER_GRAY = 3'd6;

   // Channel codes
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef struct packed {
      logic [DATA_W-1:0] data_byte;
      logic              restart;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic [COL_W-1:0] column;
      logic             end_of_row;
      logic             last_of_run;
   } rsp_type;

   // Scaling unit command and status
   typedef struct packed {
      logic               start;
      logic [VAL_W-1:0]   value;
      logic [NBITS_W-1:0] nbits;
   } scl_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [PIX_W-1:0] result;
   } scl_sts_type;

   // Mirror a byte so that its bit 0 is read first
   function automatic logic [DATA_W-1:0] rev8(input logic [DATA_W-1:0] b);
      logic [DATA_W-1:0] r;
      for (int i = 0; i < DATA_W; i++) begin
         r[DATA_W-1-i] = b[i];
      end
      return r;
   endfunction

   // All-ones mask of n bits, n from 0 to VAL_W
   function automatic logic [VAL_W-1:0] ones_mask(input logic [NBITS_W-1:0] n);
      logic [VAL_W:0] m;
      m = ((VAL_W+1)'(1) << n) - (VAL_W+1)'(1);
      return m[VAL_W-1:0];
   endfunction

endpackage

`default_nettype wire

[src/btpu_scaler.sv]
// ----------------------------------------------------------------------------
// Field scaling unit
// Scales an n-bit field v to 8 bits as floor(v*255/(2^n-1)) with a restoring
// divider that yields one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module btpu_scaler
   import btpu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  scl_req_type scl_req,
   output scl_sts_type scl_sts
);

   logic [VAL_W-1:0]   rem_ff,  rem_in;
   logic [VAL_W-1:0]   div_ff,  div_in;
   logic [PIX_W-1:0]   quo_ff,  quo_in;
   logic [2:0]         cnt_ff,  cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   logic [VAL_W+PIX_W-1:0] dividend;
   logic [VAL_W:0]         trial;
   logic [VAL_W:0]         diff;
   logic                   fits;

   // v*255 as (v << 8) - v
   assign dividend = {scl_req.value, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, scl_req.value};

   // One restoring step: bring down the next dividend bit, subtract if it fits
   assign trial = {rem_ff, quo_ff[PIX_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = (trial >= {1'b0, div_ff});

   always_comb begin
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (scl_req.start) begin
         // High part is already below the divisor since the quotient fits in 8 bits
         rem_in  = dividend[VAL_W+PIX_W-1:PIX_W];
         quo_in  = dividend[PIX_W-1:0];
         div_in  = ones_mask(scl_req.nbits);
         cnt_in  = 3'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
         quo_in = {quo_ff[PIX_W-2:0], fits};
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath needs no reset
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign scl_sts.busy   = busy_ff;
   assign scl_sts.done   = done_ff;
   assign scl_sts.result = quo_ff;

endmodule

`default_nettype wire

[src/bitstream_to_pixel_unpacker.sv]
// ----------------------------------------------------------------------------
// Bitstream to pixel unpacker
// Cuts a raw byte stream, bit 0 of each byte first, into packed RGB or gray
// pixels, scales each field to 8 bits and tags pixels with column and
// end-of-row.
//
// Usage:
//   req_* carries one byte per transfer; restart marks the first byte of a
//   new stream and clears the bit store, column and skip count.
//   rsp_* carries one pixel per transfer; last_of_run marks the final pixel
//   produced by a byte. A byte may produce zero to eight pixels.
//   csr_* writes the configuration registers; write only while idle.
// Timing:
//   The block holds req_stall high from acceptance of a byte until its last
//   pixel is loaded into the output register. Each nonzero-width field of a
//   pixel is scaled by the single shared 8-step divider; a zero-width field
//   is written as zero without it.
// Reset: synchronous; registers return to 8/8/8/8 bits, RGB, 256 pixels per
//   row, no skip; the stream state is empty.
// Stall: a pixel waits in the output register while rsp_stall is high; the
//   next pixel is not loaded until that one is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bitstream_to_pixel_unpacker
   import btpu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // byte input
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   // pixel output
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   // configuration write
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   // Sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_FIELD = 3'd2;
   localparam logic [2:0] S_WAIT  = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;

   // Configuration
   logic [NBITS_W-1:0] red_bits_ff, green_bits_ff, blue_bits_ff, gray_bits_ff;
   logic [ORDER_W-1:0] channel_order_ff;
   logic [ROW_W-1:0]   row_width_ff;
   logic [SKIP_W-1:0]  skip_bytes_ff;

   // Stream state
   logic [2:0]         state_ff,   state_in;
   logic [STORE_W-1:0] store_ff,   store_in;
   logic [HELD_W-1:0]  held_ff,    held_in;
   logic [COL_W-1:0]   col_ff,     col_in;
   logic [SKIP_W-1:0]  skipped_ff, skipped_in;
   logic [2:0]         count_ff,   count_in;
   logic [1:0]         slot_ff,    slot_in;
   logic [PIX_W-1:0]   red_ff,     red_in;
   logic [PIX_W-1:0]   green_ff,   green_in;
   logic [PIX_W-1:0]   blue_ff,    blue_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff,       rsp_in;

   // Effective configuration
   logic [NBITS_W-1:0] rb_c, gb_c, bb_c, yb_c, rb_e, yb_e;
   logic [ORDER_W-1:0] order_e;
   logic               gray_mode;
   logic [HELD_W-1:0]  bpp;
   logic [ROW_W-1:0]   width_e;

   // Field datapath
   logic [1:0]         cur_chan;
   logic [NBITS_W-1:0] cur_bits;
   logic [HELD_W-1:0]  sh_amt;
   logic [STORE_W-1:0] shifted;
   logic [VAL_W-1:0]   field_val;
   logic               slot_last;
   logic               chan_wr;
   logic [PIX_W-1:0]   chan_val;
   logic               out_free;
   logic               emit_last;
   logic               emit_eor;

   // Start-of-byte values after an optional restart
   logic [STORE_W-1:0] base_store;
   logic [HELD_W-1:0]  base_held;
   logic [COL_W-1:0]   base_col;
   logic [SKIP_W-1:0]  base_skipped;

   scl_req_type scl_req;
   scl_sts_type scl_sts;

   function automatic logic [NBITS_W-1:0] clamp_bits(input logic [NBITS_W-1:0] w);
      return (w > NBITS_W'(MAX_CHANNEL_BITS)) ? NBITS_W'(MAX_CHANNEL_BITS) : w;
   endfunction

   // Channel taken at a given slot of a pixel
   function automatic logic [1:0] slot_chan(input logic [ORDER_W-1:0] order,
                                            input logic [1:0] slot);
      logic [1:0] c0, c1, c2;
      unique case (order)
         ORDER_RBG: begin c0 = CH_RED;   c1 = CH_BLUE;  c2 = CH_GREEN; end
         ORDER_GBR: begin c0 = CH_GREEN; c1 = CH_BLUE;  c2 = CH_RED;   end
         ORDER_GRB: begin c0 = CH_GREEN; c1 = CH_RED;   c2 = CH_BLUE;  end
         ORDER_BRG: begin c0 = CH_BLUE;  c1 = CH_RED;   c2 = CH_GREEN; end
         ORDER_BGR: begin c0 = CH_BLUE;  c1 = CH_GREEN; c2 = CH_RED;   end
         default:   begin c0 = CH_RED;   c1 = CH_GREEN; c2 = CH_BLUE;  end
      endcase
      unique case (slot)
         2'd0:    return c0;
         2'd1:    return c1;
         default: return c2;
      endcase
   endfunction

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         red_bits_ff      <= NBITS_W'(8);
         green_bits_ff    <= NBITS_W'(8);
         blue_bits_ff     <= NBITS_W'(8);
         gray_bits_ff     <= NBITS_W'(8);
         channel_order_ff <= ORDER_RGB;
         row_width_ff     <= ROW_W'(256);
         skip_bytes_ff    <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_RED_BITS:      red_bits_ff      <= csr_wr_data[NBITS_W-1:0];
            REG_GREEN_BITS:    green_bits_ff    <= csr_wr_data[NBITS_W-1:0];
            REG_BLUE_BITS:     blue_bits_ff     <= csr_wr_data[NBITS_W-1:0];
            REG_GRAY_BITS:     gray_bits_ff     <= csr_wr_data[NBITS_W-1:0];
            REG_CHANNEL_ORDER: channel_order_ff <= csr_wr_data[ORDER_W-1:0];
            REG_ROW_WIDTH:     row_width_ff     <= csr_wr_data[ROW_W-1:0];
            REG_SKIP_BYTES:    skip_bytes_ff    <= csr_wr_data[SKIP_W-1:0];
            default: ;
         endcase
      end
   end

   // Saturate widths, fix up empty formats, the unused order code and the row width
   always_comb begin
      rb_c      = clamp_bits(red_bits_ff);
      gb_c      = clamp_bits(green_bits_ff);
      bb_c      = clamp_bits(blue_bits_ff);
      yb_c      = clamp_bits(gray_bits_ff);
      rb_e      = (rb_c == '0 && gb_c == '0 && bb_c == '0) ? NBITS_W'(1) : rb_c;
      yb_e      = (yb_c == '0) ? NBITS_W'(1) : yb_c;
      order_e   = (channel_order_ff > ORDER_GRAY) ? ORDER_RGB : channel_order_ff;
      gray_mode = (order_e == ORDER_GRAY);
      bpp       = gray_mode ? HELD_W'(yb_e)
                            : HELD_W'(rb_e) + HELD_W'(gb_c) + HELD_W'(bb_c);
      if (row_width_ff == '0) begin
         width_e = ROW_W'(1);
      end else if (row_width_ff > ROW_W'(MAX_ROW_WIDTH)) begin
         width_e = ROW_W'(MAX_ROW_WIDTH);
      end else begin
         width_e = row_width_ff;
      end
   end

   // Select the current field and pull it from the front of the store
   always_comb begin
      cur_chan = slot_chan(order_e, slot_ff);
      if (gray_mode) begin
         cur_bits = yb_e;
      end else begin
         unique case (cur_chan)
            CH_RED:   cur_bits = rb_e;
            CH_GREEN: cur_bits = gb_c;
            default:  cur_bits = bb_c;
         endcase
      end
      sh_amt    = held_ff - HELD_W'(cur_bits);
      shifted   = store_ff >> sh_amt;
      field_val = shifted[VAL_W-1:0] & ones_mask(cur_bits);
      slot_last = gray_mode ? (slot_ff == 2'd0) : (slot_ff == 2'd2);
   end

   // Restart clears the stream state before the byte is taken
   assign base_store   = req_data.restart ? '0 : store_ff;
   assign base_held    = req_data.restart ? '0 : held_ff;
   assign base_col     = req_data.restart ? '0 : col_ff;
   assign base_skipped = req_data.restart ? '0 : skipped_ff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // held_ff already excludes this pixel's bits here
   assign emit_last = (count_ff == 3'd7) || (held_ff < bpp);
   assign emit_eor  = (({1'b0, col_ff} + ROW_W'(1)) >= width_e);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      store_in     = store_ff;
      held_in      = held_ff;
      col_in       = col_ff;
      skipped_in   = skipped_ff;
      count_in     = count_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      chan_wr      = 1'b0;
      chan_val     = '0;
      scl_req.start = 1'b0;
      scl_req.value = field_val;
      scl_req.nbits = cur_bits;

      // Drop the output once it is taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               store_in = base_store;
               held_in  = base_held;
               col_in   = base_col;
               if (base_skipped < skip_bytes_ff) begin
                  skipped_in = base_skipped + SKIP_W'(1);
               end else begin
                  skipped_in = base_skipped;
                  store_in   = {base_store[STORE_W-DATA_W-1:0], rev8(req_data.data_byte)};
                  held_in    = base_held + HELD_W'(DATA_W);
                  count_in   = 3'd0;
                  state_in   = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (held_ff >= bpp) begin
               slot_in  = 2'd0;
               state_in = S_FIELD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_FIELD: begin
            if (cur_bits == '0) begin
               // Zero-width channel reads as zero
               chan_wr = 1'b1;
               if (slot_last) begin
                  state_in = S_EMIT;
               end else begin
                  slot_in = slot_ff + 2'd1;
               end
            end else begin
               scl_req.start = 1'b1;
               held_in       = held_ff - HELD_W'(cur_bits);
               state_in      = S_WAIT;
            end
         end
         S_WAIT: begin
            if (scl_sts.done) begin
               chan_wr  = 1'b1;
               chan_val = scl_sts.result;
               if (slot_last) begin
                  state_in = S_EMIT;
               end else begin
                  slot_in  = slot_ff + 2'd1;
                  state_in = S_FIELD;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.red         = red_ff;
               rsp_in.green       = green_ff;
               rsp_in.blue        = blue_ff;
               rsp_in.column      = col_ff;
               rsp_in.end_of_row  = emit_eor;
               rsp_in.last_of_run = emit_last;
               col_in   = emit_eor ? '0 : col_ff + COL_W'(1);
               count_in = count_ff + 3'd1;
               slot_in  = 2'd0;
               state_in = emit_last ? S_IDLE : S_FIELD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Channel value update; gray fills all three
   always_comb begin
      red_in   = red_ff;
      green_in = green_ff;
      blue_in  = blue_ff;
      if (chan_wr) begin
         if (gray_mode) begin
            red_in   = chan_val;
            green_in = chan_val;
            blue_in  = chan_val;
         end else begin
            unique case (cur_chan)
               CH_RED:   red_in   = chan_val;
               CH_GREEN: green_in = chan_val;
               default:  blue_in  = chan_val;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         store_ff     <= '0;
         held_ff      <= '0;
         col_ff       <= '0;
         skipped_ff   <= '0;
         count_ff     <= '0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         store_ff     <= store_in;
         held_ff      <= held_in;
         col_ff       <= col_in;
         skipped_ff   <= skipped_in;
         count_ff     <= count_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Pixel payload needs no reset
   always_ff @(posedge clock) begin
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
      rsp_ff   <= rsp_in;
   end

   btpu_scaler u_scaler (
      .clock   (clock),
      .reset   (reset),
      .scl_req (scl_req),
      .scl_sts (scl_sts)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   `ASSERT_IMPLIES(a_wait_has_scaler, clock, reset, state_ff == S_WAIT, scl_sts.busy || scl_sts.done, "sequencer waits on an idle scaler")
   `ASSERT_IMPLIES(a_load_from_emit, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_EMIT, "pixel loaded outside emit")
   `ASSERT_NEXT(a_last_ends_run, clock, reset, state_ff == S_EMIT && out_free && emit_last, state_ff == S_IDLE, "run did not end on its last pixel")
   `ASSERT_HOLDS(a_store_bound, clock, reset, held_ff <= HELD_W'(STORE_W - 1), "bit store overflow")

endmodule

`default_nettype wire

[dv/bitstream_to_pixel_unpacker_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitstream to pixel unpacker testbench
// Sends raw bytes through the unpacker and checks every pixel against a
// model of the bit store, channel scaling and row tracking kept in this file.
// A short table covers bit order, the channel orders, width saturation, row
// wrap, byte skipping and carry-over of held bits. Random bursts under
// random configurations follow, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------

module bitstream_to_pixel_unpacker_tb;
   import btpu_pkg::*;

   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_BYTES  = 300;
   localparam int TIMEOUT_NS    = 15_000_000;

   // Index with no register behind it
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 3'd7;

   typedef enum logic {ROW_CSR, ROW_BYTE} row_kind_type;

   // One line of the directed table: a register write or a byte
   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_DATA_W-1:0] csr_val;
      req_type               item;
      logic                  has_want;
      rsp_type               want;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   // Register copies
   logic [NBITS_W-1:0] cfg_red, cfg_green, cfg_blue, cfg_gray;
   logic [ORDER_W-1:0] cfg_order;
   logic [ROW_W-1:0]   cfg_row;
   logic [SKIP_W-1:0]  cfg_skip;

   // Stream state
   logic [STORE_W-1:0] store_bits;
   int unsigned        held;
   logic [COL_W-1:0]   col_now;
   logic [SKIP_W-1:0]  skipped;

   rsp_type      run_pixels[$];
   rsp_type      pending_pixels[$];
   plan_row_type directed_rows[$];
   int           error_count = 0;
   logic         stream_touched = 1'b0;
   logic         sender_quiet = 1'b0;
   logic         sink_quiet = 1'b0;

   bitstream_to_pixel_unpacker dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Append a line to the directed table
   function automatic void plan_add(input plan_row_type r);
      directed_rows.insert(directed_rows.size(), r);
   endfunction

   // Append a pixel to the back of a pixel queue
   function automatic void queue_pixel(ref rsp_type q[$], input rsp_type p);
      q.insert(q.size(), p);
   endfunction

   function automatic plan_row_type csr_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] val);
      plan_row_type r;
      r = '0;
      r.kind    = ROW_CSR;
      r.csr_idx = idx;
      r.csr_val = val;
      return r;
   endfunction

   function automatic plan_row_type byte_row(input logic [DATA_W-1:0] b, input logic rst,
                                             input logic has_want = 1'b0,
                                             input rsp_type want = '0);
      plan_row_type r;
      r = '0;
      r.kind           = ROW_BYTE;
      r.item.data_byte = b;
      r.item.restart   = rst;
      r.has_want       = has_want;
      r.want           = want;
      return r;
   endfunction

   // Take n bits off the front of the store and stretch them to 8 bits
   function automatic logic [PIX_W-1:0] pull_scaled(input int unsigned n);
      logic [31:0] v;
      if (n == 0) return '0;
      v = 32'((store_bits >> (held - n)) & ((56'd1 << n) - 56'd1));
      held = held - n;
      store_bits = store_bits & ((56'd1 << held) - 56'd1);
      return 8'((v * 32'd255) / ((32'd1 << n) - 32'd1));
   endfunction

   // Work out the pixels one byte releases into run_pixels
   task automatic unpack_byte(input req_type item);
      int unsigned        rb, gb, bb, yb, bpp, width, run;
      logic [ORDER_W-1:0] order;
      logic [DATA_W-1:0]  mirrored;
      rsp_type            pix;
      run_pixels.delete();
      rb = (cfg_red   > MAX_CHANNEL_BITS) ? MAX_CHANNEL_BITS : cfg_red;
      gb = (cfg_green > MAX_CHANNEL_BITS) ? MAX_CHANNEL_BITS : cfg_green;
      bb = (cfg_blue  > MAX_CHANNEL_BITS) ? MAX_CHANNEL_BITS : cfg_blue;
      yb = (cfg_gray  > MAX_CHANNEL_BITS) ? MAX_CHANNEL_BITS : cfg_gray;
      order = (cfg_order > ORDER_GRAY) ? ORDER_RGB : cfg_order;
      width = cfg_row;
      if (item.restart) begin
         store_bits = '0;
         held       = 0;
         col_now    = '0;
         skipped    = '0;
      end
      // drop leading bytes of the stream
      if (skipped < cfg_skip) begin
         skipped = skipped + 1'b1;
         return;
      end
      if (width < 1) width = 1;
      if (width > MAX_ROW_WIDTH) width = MAX_ROW_WIDTH;
      if (rb + gb + bb == 0) rb = 1;
      if (yb == 0) yb = 1;
      bpp = (order == ORDER_GRAY) ? yb : rb + gb + bb;
      for (int i = 0; i < DATA_W; i++) mirrored[DATA_W-1-i] = item.data_byte[i];
      store_bits = {store_bits[STORE_W-DATA_W-1:0], mirrored};
      held = held + DATA_W;
      run = 0;
      while (run < 8 && held >= bpp) begin
         pix = '0;
         case (order)
            ORDER_RGB: begin
               pix.red = pull_scaled(rb); pix.green = pull_scaled(gb);
               pix.blue = pull_scaled(bb);
            end
            ORDER_RBG: begin
               pix.red = pull_scaled(rb); pix.blue = pull_scaled(bb);
               pix.green = pull_scaled(gb);
            end
            ORDER_GBR: begin
               pix.green = pull_scaled(gb); pix.blue = pull_scaled(bb);
               pix.red = pull_scaled(rb);
            end
            ORDER_GRB: begin
               pix.green = pull_scaled(gb); pix.red = pull_scaled(rb);
               pix.blue = pull_scaled(bb);
            end
            ORDER_BRG: begin
               pix.blue = pull_scaled(bb); pix.red = pull_scaled(rb);
               pix.green = pull_scaled(gb);
            end
            ORDER_BGR: begin
               pix.blue = pull_scaled(bb); pix.green = pull_scaled(gb);
               pix.red = pull_scaled(rb);
            end
            default: begin
               pix.red = pull_scaled(yb);
               pix.green = pix.red;
               pix.blue = pix.red;
            end
         endcase
         // advance the column, wrapping at the row end
         pix.column = col_now;
         if (int'(col_now) + 1 >= width) begin
            pix.end_of_row = 1'b1;
            col_now = '0;
         end else begin
            col_now = col_now + 1'b1;
         end
         run++;
         pix.last_of_run = (run == 8) || (held < bpp);
         queue_pixel(run_pixels, pix);
      end
   endtask

   // Hold the sender until every pixel is back and the block has settled
   task automatic drain_stream();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      stream_touched = 1'b0;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      if (stream_touched) drain_stream();
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_RED_BITS:      cfg_red   = val[NBITS_W-1:0];
         REG_GREEN_BITS:    cfg_green = val[NBITS_W-1:0];
         REG_BLUE_BITS:     cfg_blue  = val[NBITS_W-1:0];
         REG_GRAY_BITS:     cfg_gray  = val[NBITS_W-1:0];
         REG_CHANNEL_ORDER: cfg_order = val[ORDER_W-1:0];
         REG_ROW_WIDTH:     cfg_row   = val[ROW_W-1:0];
         REG_SKIP_BYTES:    cfg_skip  = val[SKIP_W-1:0];
         default: ;
      endcase
   endtask

   // Offer one byte; keep valid high afterwards so back-to-back bytes need no drop
   task automatic send_byte(input req_type item, input logic has_want = 1'b0,
                            input rsp_type want = '0);
      int unsigned gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      unpack_byte(item);
      if (has_want) queue_pixel(pending_pixels, want);
      else foreach (run_pixels[i]) queue_pixel(pending_pixels, run_pixels[i]);
      stream_touched = 1'b1;
   endtask

   task automatic compare_field(input string field, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $display("%0t ns: pixel %s mismatch, expected %0d, actual %0d",
                  $time, field, want, got);
         error_count++;
      end
   endtask

   // Pixel side: stall a random number of cycles before each transfer
   initial begin : pixel_sink
      int unsigned hold;
      forever begin
         hold = sink_quiet ? 0 : $urandom_range(0, 16);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   // Check each pixel transfer against the oldest expected pixel
   always @(posedge clock) begin : pixel_check
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t ns: pixel mismatch, expected none, actual %h", $time, rsp_data);
            error_count++;
         end else begin
            want = pending_pixels.pop_front();
            compare_field("red", want.red, rsp_data.red);
            compare_field("green", want.green, rsp_data.green);
            compare_field("blue", want.blue, rsp_data.blue);
            compare_field("column", want.column, rsp_data.column);
            compare_field("end_of_row", want.end_of_row, rsp_data.end_of_row);
            compare_field("last_of_run", want.last_of_run, rsp_data.last_of_run);
         end
      end
   end

   initial begin : stimulus
      req_type               item;
      logic [CSR_DATA_W-1:0] setting;
      int unsigned           keep_bits, burst, sent;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_wr_en   <= 1'b0;
      csr_index   <= '0;
      csr_wr_data <= '0;
      cfg_red = 5'd8; cfg_green = 5'd8; cfg_blue = 5'd8; cfg_gray = 5'd8;
      cfg_order = ORDER_RGB; cfg_row = 13'd256; cfg_skip = '0;
      store_bits = '0; held = 0; col_now = '0; skipped = '0;

      // reset defaults: 8-bit RGB, bit 0 of each byte read first
      plan_add(byte_row(8'h00, 1'b1));
      plan_add(byte_row(8'h00, 1'b0));
      plan_add(byte_row(8'h00, 1'b0, 1'b1,
                        {8'd0, 8'd0, 8'd0, 12'd0, 1'b0, 1'b1}));
      plan_add(byte_row(8'hFF, 1'b0));
      plan_add(byte_row(8'hFF, 1'b0));
      plan_add(byte_row(8'hFF, 1'b0, 1'b1,
                        {8'd255, 8'd255, 8'd255, 12'd1, 1'b0, 1'b1}));
      plan_add(byte_row(8'h01, 1'b0));
      plan_add(byte_row(8'h00, 1'b0));
      plan_add(byte_row(8'h80, 1'b0, 1'b1,
                        {8'd128, 8'd0, 8'd1, 12'd2, 1'b0, 1'b1}));
      // one-bit gray: eight pixels per byte, then a row shrunk under the column
      plan_add(csr_row(REG_GRAY_BITS, 24'd1));
      plan_add(csr_row(REG_CHANNEL_ORDER, CSR_DATA_W'(ORDER_GRAY)));
      plan_add(byte_row(8'hA5, 1'b0));
      plan_add(csr_row(REG_ROW_WIDTH, 24'd3));
      plan_add(byte_row(8'h3C, 1'b0));
      // gray width zero and row width zero
      plan_add(csr_row(REG_GRAY_BITS, 24'd0));
      plan_add(csr_row(REG_ROW_WIDTH, 24'd0));
      plan_add(byte_row(8'hFF, 1'b1));
      // unused order code, all color widths zero, oversize row
      plan_add(csr_row(REG_CHANNEL_ORDER, 24'd7));
      plan_add(csr_row(REG_RED_BITS, 24'd0));
      plan_add(csr_row(REG_GREEN_BITS, 24'd0));
      plan_add(csr_row(REG_BLUE_BITS, 24'd0));
      plan_add(csr_row(REG_ROW_WIDTH, 24'h1FFF));
      plan_add(byte_row(8'h0F, 1'b0));
      // widest fields, one saturated; hold bits, then switch to one-bit gray
      plan_add(csr_row(REG_RED_BITS, 24'd16));
      plan_add(csr_row(REG_GREEN_BITS, 24'd31));
      plan_add(csr_row(REG_BLUE_BITS, 24'd16));
      plan_add(csr_row(REG_CHANNEL_ORDER, CSR_DATA_W'(ORDER_BGR)));
      plan_add(csr_row(REG_ROW_WIDTH, 24'd4096));
      plan_add(csr_row(REG_SPARE, 24'hFFFFFF));
      plan_add(byte_row(8'h12, 1'b1));
      plan_add(byte_row(8'h34, 1'b0));
      plan_add(byte_row(8'h56, 1'b0));
      plan_add(csr_row(REG_GRAY_BITS, 24'd1));
      plan_add(csr_row(REG_CHANNEL_ORDER, CSR_DATA_W'(ORDER_GRAY)));
      plan_add(byte_row(8'hBC, 1'b0));
      // remaining channel orders, one 4/2/2 pixel per byte
      plan_add(csr_row(REG_RED_BITS, 24'd4));
      plan_add(csr_row(REG_GREEN_BITS, 24'd2));
      plan_add(csr_row(REG_BLUE_BITS, 24'd2));
      plan_add(csr_row(REG_CHANNEL_ORDER, CSR_DATA_W'(ORDER_RBG)));
      plan_add(byte_row(8'h1B, 1'b1));
      plan_add(csr_row(REG_CHANNEL_ORDER, CSR_DATA_W'(ORDER_GBR)));
      plan_add(byte_row(8'hE4, 1'b0));
      plan_add(csr_row(REG_CHANNEL_ORDER, CSR_DATA_W'(ORDER_GRB)));
      plan_add(byte_row(8'h6D, 1'b0));
      plan_add(csr_row(REG_CHANNEL_ORDER, CSR_DATA_W'(ORDER_BRG)));
      plan_add(byte_row(8'h92, 1'b0));
      // skipped bytes after a restart, then the largest skip
      plan_add(csr_row(REG_SKIP_BYTES, 24'd2));
      plan_add(byte_row(8'hC3, 1'b1));
      plan_add(byte_row(8'h5A, 1'b0));
      plan_add(byte_row(8'h7E, 1'b0));
      plan_add(csr_row(REG_SKIP_BYTES, 24'hFFFFFF));
      plan_add(byte_row(8'h81, 1'b1));
      plan_add(csr_row(REG_SKIP_BYTES, 24'd0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR)
            write_csr(directed_rows[i].csr_idx, directed_rows[i].csr_val);
         else
            send_byte(directed_rows[i].item, directed_rows[i].has_want,
                      directed_rows[i].want);
      end

      // random bursts, each under a freshly drawn configuration
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         for (int r = 0; r < 8; r++) begin
            if ($urandom_range(0, 1) == 0) continue;
            case (CSR_IDX_W'(r))
               REG_RED_BITS, REG_GREEN_BITS, REG_BLUE_BITS, REG_GRAY_BITS: begin
                  keep_bits = NBITS_W;
                  case ($urandom_range(0, 9))
                     0:       setting = 24'd0;
                     1:       setting = 24'd16;
                     2:       setting = 24'($urandom_range(17, 31));
                     default: setting = 24'($urandom_range(1, 8));
                  endcase
               end
               REG_CHANNEL_ORDER: begin
                  keep_bits = ORDER_W;
                  setting   = 24'($urandom_range(0, 7));
               end
               REG_ROW_WIDTH: begin
                  keep_bits = ROW_W;
                  case ($urandom_range(0, 7))
                     0:       setting = 24'd0;
                     1:       setting = 24'd4096;
                     2:       setting = 24'($urandom_range(4097, 8191));
                     default: setting = 24'($urandom_range(1, 16));
                  endcase
               end
               REG_SKIP_BYTES: begin
                  keep_bits = SKIP_W;
                  case ($urandom_range(0, 15))
                     0:       setting = 24'($urandom_range(0, 24'hFFFFFF));
                     1, 2:    setting = 24'($urandom_range(1, 3));
                     default: setting = 24'd0;
                  endcase
               end
               default: begin
                  keep_bits = SKIP_W;
                  setting   = 24'($urandom);
               end
            endcase
            // junk above the register width
            if ($urandom_range(0, 3) == 0)
               setting = setting | ((24'($urandom) >> keep_bits) << keep_bits);
            write_csr(CSR_IDX_W'(r), setting);
         end
         sender_quiet = ($urandom_range(0, 3) == 0);
         sink_quiet   = ($urandom_range(0, 3) == 0);
         burst = $urandom_range(4, 24);
         for (int i = 0; i < burst; i++) begin
            item.data_byte = DATA_W'($urandom_range(0, 255));
            item.restart   = (i == 0 && $urandom_range(0, 3) != 0) ||
                             ($urandom_range(0, 31) == 0);
            send_byte(item);
         end
         sent += burst;
      end

      drain_stream();
      @(negedge clock);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("%0t ns: timeout with %0d pixels outstanding", $time,
               pending_pixels.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
